[rtl/core/stu_pkg.sv]
// ----------------------------------------------------------------------------
// stu_pkg: shared types and constants for the size-to-scaled-unit block
// Sequencer states, divider control/status bundles and fixed constants.
// ----------------------------------------------------------------------------
package stu_pkg;

   // width of the working value and of the byte-serial divider
   localparam int DIV_W     = 80;
   localparam int DIV_BYTES = DIV_W / 8;

   // unit bases, wide enough for a one-bit-grown partial remainder
   localparam logic [10:0] BASE_DEC = 11'd1000;
   localparam logic [10:0] BASE_BIN = 11'd1024;

   // reported order once the scale leaves the known units
   localparam logic [3:0] ORDER_UNKNOWN = 4'd9;

   // fraction scaling: rem * 1000 / 1024, then /10 or /100 by reciprocal
   localparam logic [19:0] FRAC_SCALE    = 20'd1000;
   localparam logic [17:0] TENTH_MUL     = 18'd205;
   localparam logic [17:0] HUNDREDTH_MUL = 18'd41;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_CHK1,
      ST_DIV1,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ADD_GO,
      ST_DIVA,
      ST_CHK3,
      ST_DIV3,
      ST_FRAC1,
      ST_FRAC2
   } stu_state_type;

   typedef struct packed {
      logic start;
      logic binary;
   } stu_div_ctrl_type;

   typedef struct packed {
      logic done;
   } stu_div_stat_type;

endpackage

[rtl/core/stu_div.sv]
// ----------------------------------------------------------------------------
// stu_div: byte-serial divider by the unit base
// Divides an 80-bit value by 1000 or 1024, eight quotient bits per cycle,
// starting at the highest nonzero byte. Quotient is built in place.
// ----------------------------------------------------------------------------
module stu_div (
   input  logic                       clock,
   input  logic                       reset,
   input  stu_pkg::stu_div_ctrl_type  div_ctrl,
   input  logic [stu_pkg::DIV_W-1:0]  div_dividend,
   output logic [stu_pkg::DIV_W-1:0]  div_quotient,
   output logic [9:0]                 div_remainder,
   output stu_pkg::stu_div_stat_type  div_stat
);
   import stu_pkg::*;

   logic [DIV_W-1:0] work_ff, work_in;
   logic [9:0]       part_ff, part_in;
   logic [3:0]       idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [3:0]       top_idx;
   logic [10:0]      divisor;
   logic [7:0]       cur_byte;
   logic [7:0]       q_byte;
   logic [9:0]       step_rem;

   assign divisor  = div_ctrl.binary ? BASE_BIN : BASE_DEC;
   assign cur_byte = work_ff[{idx_ff, 3'b000} +: 8];

   // find the highest nonzero byte of the incoming dividend
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < DIV_BYTES; i++) begin
         if (|div_dividend[i*8 +: 8]) begin
            top_idx = 4'(i);
         end
      end
   end

   // eight restoring compare-subtract steps on the current byte
   always_comb begin
      logic [10:0] r;
      r = {1'b0, part_ff};
      for (int b = 7; b >= 0; b--) begin
         r = {r[9:0], cur_byte[b]};
         if (r >= divisor) begin
            r         = r - divisor;
            q_byte[b] = 1'b1;
         end else begin
            q_byte[b] = 1'b0;
         end
      end
      step_rem = r[9:0];
   end

   // load on start, then walk down one byte per cycle
   always_comb begin
      work_in = work_ff;
      part_in = part_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctrl.start) begin
         work_in = div_dividend;
         part_in = '0;
         idx_in  = top_idx;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in[{idx_ff, 3'b000} +: 8] = q_byte;
         part_in = step_rem;
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      part_ff <= part_in;
      idx_ff  <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_quotient  = work_ff;
   assign div_remainder = part_ff;
   assign div_stat.done = done_ff;

endmodule

[rtl/core/size_to_scaled_unit.sv]
// ----------------------------------------------------------------------------
// size_to_scaled_unit: scale count * block size to a power of 1000 or 1024
// Reduces the count, forms the exact product, normalizes it below the base
// and splits it into whole part, truncated fraction digits and unit order.
// ----------------------------------------------------------------------------
// Latency: a zero count skips the arithmetic; otherwise the time grows with
//   the significant dividend bytes of each division by the base, the carry
//   division included, as the byte-serial divider walks them one by one.
// Throughput: one item at a time; req_ready is high only while idle, and
//   a finished result waits in the output register while the next is taken.
// Reset: synchronous, clears the sequencer, rsp_valid and unit_base (1000).
module size_to_scaled_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_block_count,
   input  logic [31:0] req_block_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_whole_part,
   output logic [6:0]  rsp_fraction_value,
   output logic [1:0]  rsp_fraction_digits,
   output logic [3:0]  rsp_unit_order,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import stu_pkg::*;

   stu_state_type state_ff, state_in;

   logic             base_ff, base_in;
   logic [63:0]      size_ff, size_in;
   logic [31:0]      blk_ff, blk_in;
   logic [41:0]      limit_ff, limit_in;
   logic [DIV_W-1:0] n_ff, n_in;
   logic [41:0]      mr_ff, mr_in;
   logic [9:0]       rem_ff, rem_in;
   logic [9:0]       v_ff, v_in;
   logic [3:0]       order_ff, order_in;
   logic             zero_ff, zero_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [9:0]       whole_ff, whole_in;
   logic [6:0]       fval_ff, fval_in;
   logic [1:0]       fdig_ff, fdig_in;
   logic [3:0]       uord_ff, uord_in;

   stu_div_ctrl_type div_ctrl;
   stu_div_stat_type div_stat;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_quotient;
   logic [9:0]       div_remainder;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;
   logic [10:0]      base_val;
   logic             req_xfer;
   logic             out_free;
   logic             size_gt;
   logic             n_ge;
   logic [3:0]       order_inc;
   logic [19:0]      frac_scaled;
   logic [17:0]      tenth_p;
   logic [17:0]      hund_p;
   logic [1:0]       digits;

   assign base_val  = base_ff ? BASE_BIN : BASE_DEC;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign size_gt   = size_ff > {22'd0, limit_ff};
   assign n_ge      = n_ff >= {{(DIV_W-11){1'b0}}, base_val};
   assign order_inc = (order_ff == ORDER_UNKNOWN) ? ORDER_UNKNOWN : order_ff + 4'd1;

   // shared 32x32 multiplier
   assign mul_p = mul_a * mul_b;

   // fraction helpers: scale binary remainder, then reciprocal /10 and /100
   assign frac_scaled = {10'd0, rem_ff} * FRAC_SCALE;
   assign tenth_p     = {8'd0, v_ff} * TENTH_MUL;
   assign hund_p      = {8'd0, v_ff} * HUNDREDTH_MUL;

   // shown fraction digit count from the whole part
   always_comb begin
      priority if (zero_ff)              digits = 2'd0;
      else if (n_ff[9:0] < 10'd10)       digits = 2'd2;
      else if (n_ff[9:0] < 10'd100)      digits = 2'd1;
      else                               digits = 2'd0;
   end

   stu_div u_div (
      .clock         (clock),
      .reset         (reset),
      .div_ctrl      (div_ctrl),
      .div_dividend  (div_dividend),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder),
      .div_stat      (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_block_count == 64'd0) ? ST_FRAC1 : ST_LIMIT;
            end
         end
         ST_LIMIT:  state_in = ST_CHK1;
         ST_CHK1:   state_in = size_gt ? ST_DIV1 : ST_MUL0;
         ST_DIV1:   if (div_stat.done) state_in = ST_CHK1;
         ST_MUL0:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_ADD_GO;
         ST_ADD_GO: state_in = ST_DIVA;
         ST_DIVA:   if (div_stat.done) state_in = ST_CHK3;
         ST_CHK3:   state_in = n_ge ? ST_DIV3 : ST_FRAC1;
         ST_DIV3:   if (div_stat.done) state_in = ST_CHK3;
         ST_FRAC1:  state_in = ST_FRAC2;
         ST_FRAC2:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, multiplier operands, divider start
   always_comb begin
      req_ready       = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      div_ctrl.start  = 1'b0;
      div_ctrl.binary = base_ff;
      div_dividend    = n_ff;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_LIMIT: begin
            mul_a = blk_ff;
            mul_b = {21'd0, base_val};
         end
         ST_CHK1: begin
            div_ctrl.start = size_gt;
            div_dividend   = {16'd0, size_ff};
         end
         ST_MUL0: begin
            mul_a = size_ff[31:0];
            mul_b = blk_ff;
         end
         ST_MUL1: begin
            mul_a = size_ff[63:32];
            mul_b = blk_ff;
         end
         ST_MUL2: begin
            mul_a = {22'd0, rem_ff};
            mul_b = blk_ff;
         end
         ST_ADD_GO: begin
            div_ctrl.start = 1'b1;
            div_dividend   = {38'd0, mr_ff};
         end
         ST_CHK3:  div_ctrl.start = n_ge;
         default: ;
      endcase
   end

   // datapath updates
   always_comb begin
      base_in      = csr_wr_en ? csr_wr_data : base_ff;
      size_in      = size_ff;
      blk_in       = blk_ff;
      limit_in     = limit_ff;
      n_in         = n_ff;
      mr_in        = mr_ff;
      rem_in       = rem_ff;
      v_in         = v_ff;
      order_in     = order_ff;
      zero_in      = zero_ff;
      whole_in     = whole_ff;
      fval_in      = fval_ff;
      fdig_in      = fdig_ff;
      uord_in      = uord_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               size_in  = req_block_count;
               blk_in   = req_block_bytes;
               n_in     = '0;
               rem_in   = '0;
               order_in = '0;
               zero_in  = (req_block_count == 64'd0);
            end
         end
         ST_LIMIT: limit_in = mul_p[41:0];
         ST_DIV1: begin
            if (div_stat.done) begin
               size_in  = div_quotient[63:0];
               rem_in   = div_remainder;
               order_in = order_inc;
            end
         end
         // low partial product, then high one shifted up a word
         ST_MUL0: n_in  = {16'd0, mul_p};
         ST_MUL1: n_in  = n_ff + {mul_p[47:0], 32'd0};
         ST_MUL2: mr_in = mul_p[41:0];
         // carry the scaled remainder's whole units into the product
         ST_DIVA: begin
            if (div_stat.done) begin
               n_in   = n_ff + div_quotient;
               rem_in = div_remainder;
            end
         end
         ST_DIV3: begin
            if (div_stat.done) begin
               n_in     = div_quotient;
               rem_in   = div_remainder;
               order_in = order_inc;
            end
         end
         ST_FRAC1: v_in = base_ff ? frac_scaled[19:10] : rem_ff;
         ST_FRAC2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               whole_in     = n_ff[9:0];
               fdig_in      = digits;
               uord_in      = order_ff;
               unique case (digits)
                  2'd2:    fval_in = tenth_p[17:11];
                  2'd1:    fval_in = {3'd0, hund_p[15:12]};
                  default: fval_in = '0;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      blk_ff   <= blk_in;
      limit_ff <= limit_in;
      n_ff     <= n_in;
      mr_ff    <= mr_in;
      rem_ff   <= rem_in;
      v_ff     <= v_in;
      order_ff <= order_in;
      zero_ff  <= zero_in;
      whole_ff <= whole_in;
      fval_ff  <= fval_in;
      fdig_ff  <= fdig_in;
      uord_ff  <= uord_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_whole_part      = whole_ff;
   assign rsp_fraction_value  = fval_ff;
   assign rsp_fraction_digits = fdig_ff;
   assign rsp_unit_order      = uord_ff;

endmodule

[rtl/core/stu_check.sv]
// ----------------------------------------------------------------------------
// stu_check: port-level checks for size_to_scaled_unit
// Watches the request, response and result fields over time.
// ----------------------------------------------------------------------------
module stu_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_whole_part,
   input logic [6:0]  rsp_fraction_value,
   input logic [1:0]  rsp_fraction_digits,
   input logic [3:0]  rsp_unit_order
);

   // a pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_whole_part)
         && $stable(rsp_fraction_value) && $stable(rsp_fraction_digits)
         && $stable(rsp_unit_order))
      else $error("response changed while stalled");

   // one item in flight: the request side closes right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in progress");

   // order and digit count stay within their codes
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_order <= 4'd9 && rsp_fraction_digits <= 2'd2)
      else $error("response order or digit count out of range");

   // one fraction digit means a two-digit whole part and a single digit
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fraction_digits == 2'd1 |->
         rsp_whole_part >= 10'd10 && rsp_whole_part < 10'd100
         && rsp_fraction_value < 7'd10)
      else $error("one-digit fraction with inconsistent whole part");

   // no fraction shown means no fraction value
   a_no_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fraction_digits == 2'd0 |-> rsp_fraction_value == 7'd0)
      else $error("fraction value without fraction digits");

endmodule

bind size_to_scaled_unit stu_check u_stu_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_whole_part      (rsp_whole_part),
   .rsp_fraction_value  (rsp_fraction_value),
   .rsp_fraction_digits (rsp_fraction_digits),
   .rsp_unit_order      (rsp_unit_order)
);

[sim/scaled_size_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_size_checker: result predictor and scoreboard for size_to_scaled_unit
// Watches the request, result and register ports, works out the scaled size
// for every accepted request and compares each result transfer in order.
// ----------------------------------------------------------------------------
module scaled_size_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_block_count,
   input  logic [31:0] req_block_bytes,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [9:0]  rsp_whole_part,
   input  logic [6:0]  rsp_fraction_value,
   input  logic [1:0]  rsp_fraction_digits,
   input  logic [3:0]  rsp_unit_order,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          failures,
   output int          pending
);
   import stu_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [9:0] whole;
      logic [6:0] frac;
      logic [1:0] digits;
      logic [3:0] order;
   } scaled_size_type;

   typedef struct {
      logic [63:0]     count;
      logic [31:0]     bytes;
      logic            binary;
      scaled_size_type want;
   } size_request_type;

   size_request_type scaled_q[$];
   size_request_type head;
   scaled_size_type  seen;
   logic             binary_units;
   int               result_count;

   // Scale count * bytes to a power of the base, with two, one or no fraction digits
   function automatic scaled_size_type scale_size(input logic [63:0] count,
                                                  input logic [31:0] bytes,
                                                  input logic        binary);
      logic [63:0]     base;
      logic [63:0]     reduced;
      logic [63:0]     leftover;
      logic [63:0]     bound;
      logic [63:0]     carry;
      logic [63:0]     per_mille;
      logic [63:0]     shown;
      logic [95:0]     product;
      int unsigned     order;
      scaled_size_type res;
      base = {53'd0, binary ? BASE_BIN : BASE_DEC};
      res = '0;
      if (count == 64'd0) begin
         return res;
      end
      reduced  = count;
      leftover = 64'd0;
      order    = 0;
      bound    = {32'd0, bytes} * base;
      // reduce the count first so the product stays small
      while (reduced > bound) begin
         leftover = reduced % base;
         reduced  = reduced / base;
         order++;
      end
      // exact product, with the scaled remainder carried into it
      product  = {32'd0, reduced};
      product  = product * {64'd0, bytes};
      leftover = leftover * {32'd0, bytes};
      carry    = leftover / base;
      leftover = leftover % base;
      product  = product + {32'd0, carry};
      // normalize until the whole part is below the base
      while (product >= {32'd0, base}) begin
         leftover = 64'(product % {32'd0, base});
         product  = product / {32'd0, base};
         order++;
      end
      res.whole = product[9:0];
      if (product < 96'd10) begin
         res.digits = 2'd2;
      end else if (product < 96'd100) begin
         res.digits = 2'd1;
      end else begin
         res.digits = 2'd0;
      end
      // truncated fraction, never rounded
      per_mille = leftover * 64'd1000 / base;
      shown     = 64'd0;
      if (res.digits == 2'd2) begin
         shown = per_mille / 64'd10;
      end else if (res.digits == 2'd1) begin
         shown = per_mille / 64'd100;
      end
      res.frac  = shown[6:0];
      res.order = (order > 9) ? ORDER_UNKNOWN : order[3:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         binary_units = 1'b0;
         scaled_q.delete();
         failures     = 0;
         pending      = 0;
         result_count = 0;
      end else begin
         // compare each result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_whole_part, rsp_fraction_value, rsp_fraction_digits,
                    rsp_unit_order};
            if (scaled_q.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("result %0d with none pending: whole=%0d frac=%0d",
                           result_count, seen.whole, seen.frac);
                  $display("   digits=%0d order=%0d", seen.digits, seen.order);
               end
            end else begin
               head = scaled_q.pop_front();
               if (seen !== head.want) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("result %0d count=%0d bytes=%0d base=%0d", result_count,
                              head.count, head.bytes, head.binary ? 1024 : 1000);
                     $display("   expected whole=%0d frac=%0d digits=%0d order=%0d",
                              head.want.whole, head.want.frac, head.want.digits,
                              head.want.order);
                     $display("   actual   whole=%0d frac=%0d digits=%0d order=%0d",
                              seen.whole, seen.frac, seen.digits, seen.order);
                  end
               end
            end
            result_count++;
         end
         // predict the result of each request transfer
         if (req_valid && req_ready) begin
            head.count  = req_block_count;
            head.bytes  = req_block_bytes;
            head.binary = binary_units;
            head.want   = scale_size(req_block_count, req_block_bytes, binary_units);
            scaled_q.push_back(head);
         end
         // track the unit base register
         if (csr_wr_en) begin
            binary_units = csr_wr_data;
         end
         pending = scaled_q.size();
      end
   end

endmodule

[sim/size_to_scaled_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_to_scaled_unit_tb: regression bench for the size scaling block
// Runs directed corner sizes under both unit bases, then random sizes over
// several idle and backpressure phases; a checker predicts every result.
// ----------------------------------------------------------------------------
module size_to_scaled_unit_tb;

   import stu_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int SEGMENTS      = 8;
   localparam int SEG_ITEMS     = 63;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int IDLE_PCT[4]   = '{0, 49, 0, 22};
   localparam int STALL_PCT[4]  = '{0, 0, 49, 22};

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [63:0] req_block_count     = 64'd0;
   logic [31:0] req_block_bytes     = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [9:0]  rsp_whole_part;
   logic [6:0]  rsp_fraction_value;
   logic [1:0]  rsp_fraction_digits;
   logic [3:0]  rsp_unit_order;
   logic        csr_wr_en           = 1'b0;
   logic        csr_wr_data         = 1'b0;

   int          mismatches;
   int          pending;
   int          idle_pct            = 0;
   int          stall_pct           = 0;
   int          cycle_count;
   int          seg;
   logic [63:0] next_count;
   logic [31:0] next_bytes;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   size_to_scaled_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_block_count     (req_block_count),
      .req_block_bytes     (req_block_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_whole_part      (rsp_whole_part),
      .rsp_fraction_value  (rsp_fraction_value),
      .rsp_fraction_digits (rsp_fraction_digits),
      .rsp_unit_order      (rsp_unit_order),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   scaled_size_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_block_count     (req_block_count),
      .req_block_bytes     (req_block_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_whole_part      (rsp_whole_part),
      .rsp_fraction_value  (rsp_fraction_value),
      .rsp_fraction_digits (rsp_fraction_digits),
      .rsp_unit_order      (rsp_unit_order),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .failures            (mismatches),
      .pending             (pending)
   );

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hold a request until its transfer; leave valid high for the next one
   task automatic send_size(input logic [63:0] count, input logic [31:0] bytes);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_block_count <= count;
      req_block_bytes <= bytes;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_sizes();
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_unit_base(input logic binary);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= binary;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Corner sizes: zero count, zero block size, full range, base boundaries
   task automatic send_corner_sizes();
      send_size(64'd0, 32'd512);
      send_size(64'd0, 32'd0);
      send_size(64'd1, 32'd0);
      send_size('1, 32'd0);
      send_size('1, '1);
      send_size('1, 32'd1);
      send_size(64'd1, 32'd1);
      send_size(64'd10, 32'd1);
      send_size(64'd999, 32'd1);
      send_size(64'd1000, 32'd1);
      send_size(64'd1023, 32'd1);
      send_size(64'd1024, 32'd1);
      send_size(64'd1234567, 32'd512);
   endtask

   task automatic pick_size(output logic [63:0] count, output logic [31:0] bytes);
      logic [63:0] power;
      logic [10:0] step;
      int unsigned steps;
      case ($urandom_range(9))
         0: begin
            // typical disk sizes: modest counts of power-of-two blocks
            count = {32'd0, $urandom >> $urandom_range(31, 8)};
            bytes = 32'd1 << $urandom_range(12);
         end
         1, 2, 3, 4: begin
            count = {$urandom, $urandom} >> $urandom_range(63);
            bytes = $urandom >> $urandom_range(31);
         end
         5, 6: begin
            count = {$urandom, $urandom};
            bytes = $urandom;
         end
         7: begin
            if ($urandom_range(1) == 0) begin
               count = 64'd0;
               bytes = $urandom;
            end else begin
               count = {$urandom, $urandom} >> $urandom_range(63);
               bytes = 32'd0;
            end
         end
         8: begin
            // land just around a power of either base
            step  = $urandom_range(1) ? BASE_BIN : BASE_DEC;
            steps = $urandom_range(6, 1);
            power = 64'd1;
            repeat (steps) power = power * {53'd0, step};
            count = power - 64'd1 + {32'd0, $urandom_range(2)};
            bytes = 32'd1;
         end
         default: begin
            count = {32'd0, $urandom_range(100, 1)};
            bytes = $urandom;
         end
      endcase
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      write_unit_base(1'b0);
      send_corner_sizes();
      drain_sizes();
      write_unit_base(1'b1);
      send_corner_sizes();
      drain_sizes();
      // random sizes, alternating the base over each idle phase
      for (seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct  = IDLE_PCT[seg / 2];
         stall_pct = STALL_PCT[seg / 2];
         write_unit_base(seg % 2 == 1);
         repeat (SEG_ITEMS) begin
            pick_size(next_count, next_bytes);
            send_size(next_count, next_bytes);
         end
         drain_sizes();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[size_to_scaled_unit.f]
rtl/core/stu_pkg.sv
rtl/core/stu_div.sv
rtl/core/size_to_scaled_unit.sv
rtl/core/stu_check.sv
sim/scaled_size_checker.sv
sim/size_to_scaled_unit_tb.sv
